### rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and helpers for the sphere-sphere contact pipeline.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // three 32-bit lanes, x in element 0
  typedef logic [2:0][31:0] vec3_t;

  // request context carried from the front end through the root unit
  typedef struct packed {
    logic        hit;
    vec3_t       d;
    vec3_t       bc;
    logic [29:0] ra;
    logic [30:0] rsum;
  } ctx_t;

  // context carried through the divider lanes
  typedef struct packed {
    logic        hit;
    logic        zero;
    logic [30:0] pen;
    logic [32:0] scale;
    logic [2:0]  neg;
    vec3_t       bc;
  } sph_t;

  // finished result
  typedef struct packed {
    logic             hit;
    logic [30:0]      pen;
    logic [2:0][17:0] nrm;
    vec3_t            con;
  } res_t;

  // clamp a 34-bit signed value to signed 32 bits
  function automatic logic [31:0] sat32(input logic [33:0] v);
    logic [31:0] r;
    if (!v[33] && (v[32:31] != 2'b00)) begin
      r = 32'h7FFF_FFFF;
    end else if (v[33] && (v[32:31] != 2'b11)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/ssc_front.sv
// ----------------------------------------------------------------------------
// ssc_front
// Center difference, squares, sum of squares and the hit compare (4 stages).
// ----------------------------------------------------------------------------
module ssc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  ssc_pkg::vec3_t a_c,
  input  logic [29:0]   ar,
  input  ssc_pkg::vec3_t b_c,
  input  logic [29:0]   br,
  output logic          out_valid,
  output ssc_pkg::ctx_t out_ctx,
  output logic [63:0]   out_sumsq
);
  import ssc_pkg::*;

  logic        v1_r, v2_r, v3_r, v4_r;
  ctx_t        c1_r, c2_r, c3_r, c4_r;
  ctx_t        c1_nxt;
  ctx_t        c4_nxt;
  logic [2:0][62:0] sq2_r;
  logic [61:0] rsq2_r, rsq3_r;
  logic [63:0] sum3_r, sum4_r;
  logic [33:0] diff;
  logic signed [63:0] prod [3];

  // saturated difference and radius sum
  always_comb begin
    c1_nxt      = '0;
    c1_nxt.bc   = b_c;
    c1_nxt.ra   = ar;
    c1_nxt.rsum = {1'b0, ar} + {1'b0, br};
    diff        = '0;
    for (int i = 0; i < 3; i++) begin
      diff        = {{2{a_c[i][31]}}, a_c[i]} - {{2{b_c[i][31]}}, b_c[i]};
      c1_nxt.d[i] = sat32(diff);
    end
  end

  // squares of the difference lanes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = $signed(c1_r.d[i]) * $signed(c1_r.d[i]);
    end
  end

  // hit compare merged into the stage 4 context
  always_comb begin
    c4_nxt     = c3_r;
    c4_nxt.hit = sum3_r < {2'b00, rsq3_r};
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      c1_r   <= c1_nxt;
      c2_r   <= c1_r;
      for (int i = 0; i < 3; i++) begin
        sq2_r[i] <= prod[i][62:0];
      end
      rsq2_r <= c1_r.rsum * c1_r.rsum;
      c3_r   <= c2_r;
      sum3_r <= {1'b0, sq2_r[0]} + {1'b0, sq2_r[1]} + {1'b0, sq2_r[2]};
      rsq3_r <= rsq2_r;
      c4_r   <= c4_nxt;
      sum4_r <= sum3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_ctx   = c4_r;
  assign out_sumsq = sum4_r;

endmodule

### rtl/ssc_isqrt.sv
// ----------------------------------------------------------------------------
// ssc_isqrt
// Integer square root, one result bit per register stage (32 stages).
// ----------------------------------------------------------------------------
module ssc_isqrt (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  ssc_pkg::ctx_t in_ctx,
  input  logic [63:0]   in_sumsq,
  output logic          out_valid,
  output ssc_pkg::ctx_t out_ctx,
  output logic [31:0]   out_dist
);
  import ssc_pkg::*;

  localparam int STEPS = 32;

  logic        v_s   [0:STEPS];
  ctx_t        ctx_s [0:STEPS];
  logic [63:0] n_s   [0:STEPS];
  logic [63:0] res_s [0:STEPS];

  assign v_s[0]   = in_valid;
  assign ctx_s[0] = in_ctx;
  assign n_s[0]   = in_sumsq;
  assign res_s[0] = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial, n_nxt, res_nxt;

    // try to take the current bit
    always_comb begin
      trial = res_s[k] + BIT;
      if (n_s[k] >= trial) begin
        n_nxt   = n_s[k] - trial;
        res_nxt = (res_s[k] >> 1) + BIT;
      end else begin
        n_nxt   = n_s[k];
        res_nxt = res_s[k] >> 1;
      end
    end

    logic v_r;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_s[k];
      end
    end

    ctx_t        ctx_r;
    logic [63:0] n_r, res_r;
    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r <= ctx_s[k];
        n_r   <= n_nxt;
        res_r <= res_nxt;
      end
    end

    assign v_s[k+1]   = v_r;
    assign ctx_s[k+1] = ctx_r;
    assign n_s[k+1]   = n_r;
    assign res_s[k+1] = res_r;
  end

  assign out_valid = v_s[STEPS];
  assign out_ctx   = ctx_s[STEPS];
  assign out_dist  = res_s[STEPS][31:0];

endmodule

### rtl/ssc_div.sv
// ----------------------------------------------------------------------------
// ssc_div
// Normal lanes: |d| / dist with rounding, three restoring dividers side by
// side, one quotient bit per stage (FRAC_BITS + 2 stages with the setup).
// ----------------------------------------------------------------------------
module ssc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  ssc_pkg::ctx_t             in_ctx,
  input  logic [31:0]               in_dist,
  output logic                      out_valid,
  output ssc_pkg::sph_t             out_sph,
  output logic [2:0][FRAC_BITS:0]   out_q
);
  import ssc_pkg::*;

  localparam int QW   = FRAC_BITS + 1;
  localparam int NUMW = 33 + FRAC_BITS;

  logic                  v_s   [0:QW];
  sph_t                  sph_s [0:QW];
  logic [31:0]           den_s [0:QW];
  logic [2:0][NUMW-1:0]  num_s [0:QW];
  logic [2:0][QW-1:0]    q_s   [0:QW];

  sph_t                  sph_nxt;
  logic [2:0][NUMW-1:0]  num_nxt;
  logic [31:0]           mag;

  // setup: magnitudes, rounded numerators, penetration and scale
  always_comb begin
    sph_nxt       = '0;
    sph_nxt.hit   = in_ctx.hit;
    sph_nxt.zero  = in_dist == 32'd0;
    sph_nxt.pen   = in_ctx.rsum - in_dist[30:0];
    sph_nxt.scale = {1'b0, in_dist} - {3'b000, in_ctx.ra};
    sph_nxt.bc    = in_ctx.bc;
    mag           = '0;
    for (int i = 0; i < 3; i++) begin
      sph_nxt.neg[i] = in_ctx.d[i][31];
      mag            = in_ctx.d[i][31] ? (~in_ctx.d[i] + 32'd1) : in_ctx.d[i];
      num_nxt[i]     = {1'b0, mag, {FRAC_BITS{1'b0}}} + NUMW'(in_dist >> 1);
    end
  end

  logic v0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  sph_t                 sph0_r;
  logic [31:0]          den0_r;
  logic [2:0][NUMW-1:0] num0_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sph0_r <= sph_nxt;
      den0_r <= in_dist;
      num0_r <= num_nxt;
    end
  end

  assign v_s[0]   = v0_r;
  assign sph_s[0] = sph0_r;
  assign den_s[0] = den0_r;
  assign num_s[0] = num0_r;
  assign q_s[0]   = '0;

  for (genvar j = 0; j < QW; j++) begin : g_bit
    localparam int SH = FRAC_BITS - j;
    logic [NUMW-1:0]      dsh;
    logic [2:0][NUMW-1:0] n_nxt;
    logic [2:0][QW-1:0]   q_nxt;

    assign dsh = {{(NUMW - 32){1'b0}}, den_s[j]} << SH;

    // compare and subtract in each lane
    always_comb begin
      n_nxt = num_s[j];
      q_nxt = q_s[j];
      for (int i = 0; i < 3; i++) begin
        if (num_s[j][i] >= dsh) begin
          n_nxt[i]     = num_s[j][i] - dsh;
          q_nxt[i][SH] = 1'b1;
        end
      end
    end

    logic v_r;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_s[j];
      end
    end

    sph_t                 sph_r;
    logic [31:0]          den_r;
    logic [2:0][NUMW-1:0] num_r;
    logic [2:0][QW-1:0]   q_r;
    always_ff @(posedge clk) begin
      if (en) begin
        sph_r <= sph_s[j];
        den_r <= den_s[j];
        num_r <= n_nxt;
        q_r   <= q_nxt;
      end
    end

    assign v_s[j+1]   = v_r;
    assign sph_s[j+1] = sph_r;
    assign den_s[j+1] = den_r;
    assign num_s[j+1] = num_r;
    assign q_s[j+1]   = q_r;
  end

  assign out_valid = v_s[QW];
  assign out_sph   = sph_s[QW];
  assign out_q     = q_s[QW];

endmodule

### rtl/ssc_back.sv
// ----------------------------------------------------------------------------
// ssc_back
// Signed normal, contact offset product, rounding and the saturated contact
// point (5 stages). Misses leave as all zeros.
// ----------------------------------------------------------------------------
module ssc_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  ssc_pkg::sph_t           in_sph,
  input  logic [2:0][FRAC_BITS:0] in_q,
  output logic                    out_valid,
  output ssc_pkg::res_t           out_res
);
  import ssc_pkg::*;

  localparam int NW = FRAC_BITS + 2;
  localparam int PW = NW + 33;
  localparam int RW = 34;
  localparam logic [PW:0]   HALF = (PW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [NW-1:0] ONE  = NW'(1) << FRAC_BITS;

  logic                 v1_r, v2_r, v3_r, v4_r, v5_r;
  sph_t                 s1_r, s2_r, s3_r, s4_r;
  logic [2:0][NW-1:0]   n1_r, n2_r, n3_r, n4_r;
  logic [2:0][NW-1:0]   n_nxt;
  logic [2:0][PW-1:0]   p2_r, m3_r;
  logic [2:0]           neg3_r;
  logic [2:0][RW-1:0]   r4_r;
  logic signed [PW-1:0] prod [3];
  logic [PW:0]          rnd  [3];
  logic [RW-1:0]        rmag [3];
  logic [RW-1:0]        sum5 [3];
  logic [NW+17:0]       nwide [3];
  res_t                 res_nxt, res_r;

  // signed normal; coincident centers point along +y
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (in_sph.zero) begin
        n_nxt[i] = (i == 1) ? ONE : '0;
      end else if (in_sph.neg[i]) begin
        n_nxt[i] = ~{1'b0, in_q[i]} + NW'(1);
      end else begin
        n_nxt[i] = {1'b0, in_q[i]};
      end
    end
  end

  // normal times (b radius - penetration)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = $signed(n1_r[i]) * $signed(s1_r.scale);
    end
  end

  // round half away from zero and shift down
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]  = ({1'b0, m3_r[i]} + HALF) >> FRAC_BITS;
      rmag[i] = rnd[i][RW-1:0];
    end
  end

  // add the b center, saturate, zero out misses
  always_comb begin
    res_nxt     = '0;
    res_nxt.hit = s4_r.hit;
    res_nxt.pen = s4_r.hit ? s4_r.pen : '0;
    for (int i = 0; i < 3; i++) begin
      sum5[i]  = {{2{s4_r.bc[i][31]}}, s4_r.bc[i]} + r4_r[i];
      nwide[i] = {{18{n4_r[i][NW-1]}}, n4_r[i]};
      if (s4_r.hit) begin
        res_nxt.nrm[i] = nwide[i][17:0];
        res_nxt.con[i] = sat32(sum5[i]);
      end
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= in_sph;
      n1_r <= n_nxt;
      s2_r <= s1_r;
      n2_r <= n1_r;
      for (int i = 0; i < 3; i++) begin
        p2_r[i]   <= prod[i];
        neg3_r[i] <= p2_r[i][PW-1];
        m3_r[i]   <= p2_r[i][PW-1] ? (~p2_r[i] + PW'(1)) : p2_r[i];
        r4_r[i]   <= neg3_r[i] ? (~rmag[i] + RW'(1)) : rmag[i];
      end
      s3_r  <= s2_r;
      n3_r  <= n2_r;
      s4_r  <= s3_r;
      n4_r  <= n3_r;
      res_r <= res_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_res   = res_r;

endmodule

### rtl/sphere_sphere_contact_core.sv
// ----------------------------------------------------------------------------
// sphere_sphere_contact_core
// Sphere pair contact test: hit flag, penetration depth, unit normal and
// contact point in signed fixed point.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_*    | in  | in_tvalid/tready   | two spheres, 252 bits in 256
//  out_*   | out | out_tvalid/tready  | contact result, 182 bits in 184
//
//  One pair accepted per cycle while the skid register is empty; the depth is
//  set by the 32-stage root and the FRAC_BITS + 2 divider stages.
//  Reset clears only the valid bits; no state survives between pairs.
//  A stalled result moves into a skid register; the pipeline freezes only
//  while that register is full, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module sphere_sphere_contact_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_center_x, a_center_y, a_center_z, a_radius,
  // b_center_x, b_center_y, b_center_z, b_radius, zero pad
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit, penetration, normal_x, normal_y, normal_z,
  // contact_x, contact_y, contact_z, zero pad
  output logic [183:0] out_tdata
);
  import ssc_pkg::*;

  logic        en;
  vec3_t       a_c, b_c;
  logic [29:0] ar, br;

  logic        f_v;
  ctx_t        f_ctx;
  logic [63:0] f_sumsq;
  logic        r_v;
  ctx_t        r_ctx;
  logic [31:0] r_dist;
  logic        d_v;
  sph_t        d_sph;
  logic [2:0][FRAC_BITS:0] d_q;
  logic        b_v;
  res_t        b_res;

  logic        skid_v_r;
  res_t        skid_r;
  res_t        out_w;

  // unpack the request
  assign a_c[0] = in_tdata[31:0];
  assign a_c[1] = in_tdata[63:32];
  assign a_c[2] = in_tdata[95:64];
  assign ar     = in_tdata[125:96];
  assign b_c[0] = in_tdata[157:126];
  assign b_c[1] = in_tdata[189:158];
  assign b_c[2] = in_tdata[221:190];
  assign br     = in_tdata[251:222];

  // pipeline advances whenever the skid register is free
  assign en        = !skid_v_r;
  assign in_tready = en;

  ssc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .a_c       (a_c),
    .ar        (ar),
    .b_c       (b_c),
    .br        (br),
    .out_valid (f_v),
    .out_ctx   (f_ctx),
    .out_sumsq (f_sumsq)
  );

  ssc_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_v),
    .in_ctx    (f_ctx),
    .in_sumsq  (f_sumsq),
    .out_valid (r_v),
    .out_ctx   (r_ctx),
    .out_dist  (r_dist)
  );

  ssc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (r_v),
    .in_ctx    (r_ctx),
    .in_dist   (r_dist),
    .out_valid (d_v),
    .out_sph   (d_sph),
    .out_q     (d_q)
  );

  ssc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_v),
    .in_sph    (d_sph),
    .in_q      (d_q),
    .out_valid (b_v),
    .out_res   (b_res)
  );

  // skid: catch the last stage when the consumer stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      skid_v_r <= !out_tready;
    end else begin
      skid_v_r <= b_v && !out_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_r <= b_res;
    end
  end

  // older result in the skid goes first
  assign out_w      = skid_v_r ? skid_r : b_res;
  assign out_tvalid = skid_v_r || b_v;
  assign out_tdata  = {2'b00, out_w.con[2], out_w.con[1], out_w.con[0],
                       out_w.nrm[2], out_w.nrm[1], out_w.nrm[0],
                       out_w.pen, out_w.hit};

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_w.hit) |->
      (out_w.pen == '0 && out_w.nrm == '0 && out_w.con == '0))
    else $error("miss result carries nonzero fields");

  a_hit_pen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_w.hit) |-> (out_w.pen != '0))
    else $error("hit with zero penetration");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_tready) |=> (skid_v_r && $stable(skid_r)))
    else $error("stalled skid result lost or changed");
`endif

endmodule
